// ===== rtl/advert_app_data_parser_unit_assert.svh =====
// Assertion macros for the advertisement data parser unit.
`ifndef ADVERT_APP_DATA_PARSER_UNIT_ASSERT_SVH
`define ADVERT_APP_DATA_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ADP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ADP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADP_ASSERT(lbl, clk, rst, prop, msg)
`define ADP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/adp_pkg.sv =====
// Shared types and constants of the advertisement data parser unit.
package adp_pkg;

   localparam int NAME_CAPACITY_DEF = 32;
   localparam int RSP_DEPTH         = 4;
   localparam int RSP_PTR_W         = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W         = RSP_PTR_W + 1;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [6:0]         name_char;
      logic               record_valid;
      logic [3:0]         node_class;
      logic               loc_present;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic               name_present;
      logic [4:0]         name_length;
      logic               last_result;
   } result_type;

   // Results of one accepted byte: how many, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } parse_out_type;

endpackage

// ===== rtl/advert_app_data_parser_unit.sv =====
// Advertisement data record parser: one record byte per transaction in, results out.
// Usage: feed one record byte per req transaction (req_valid/req_ready), marking the
// final byte with req_last_byte, or send a single transaction with req_empty_record
// set for a zero-length record. The rsp channel (rsp_valid/rsp_ready) returns results:
// kind 0 carries one accepted printable name character, kind 1 carries the record
// summary that follows the final byte. rsp_last_result marks the final result of a
// request transaction; bytes that cause no result produce nothing on rsp.
// Results are written into the result queue and leave on rsp from its head.
// Throughput: one request per cycle while req_ready is high. Each byte updates the
// parser state in a single pass; results wait in a four-entry queue that drains one
// result per cycle while rsp_ready is high, so a final name byte that yields both a
// character and a summary takes two queue entries.
// Stall: req_ready drops while the queue holds more than two results, so a stalled
// receiver holds back the sender without losing a transaction.
// Reset (synchronous, active high): return the parser to the flags byte, clear all
// partial record fields and empty the result queue.
module advert_app_data_parser_unit #(
   parameter int NAME_CAPACITY = adp_pkg::NAME_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               req_empty_record,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [6:0]         rsp_name_char,
   output logic               rsp_record_valid,
   output logic [3:0]         rsp_node_class,
   output logic               rsp_loc_present,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic               rsp_name_present,
   output logic [4:0]         rsp_name_length,
   output logic               rsp_last_result
);

   `include "advert_app_data_parser_unit_assert.svh"

   logic                   req_fire;
   adp_pkg::parse_out_type parse_out;
   adp_pkg::result_type    head;
   logic                   empty_fire;
   logic                   trunc_head;
   logic                   trunc_clean;
   logic                   char_head;
   logic                   char_print;

   // Take a request only when the queue can absorb both possible results.
   assign req_fire = req_valid && req_ready;

   adp_parser #(
      .NAME_CAPACITY (NAME_CAPACITY)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_fire),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .empty_record (req_empty_record),
      .parse_out    (parse_out)
   );

   adp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .parse_out (parse_out),
      .pop       (rsp_ready),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_data  (head)
   );

   // Drive the result fields from the queue head.
   assign rsp_kind         = head.kind;
   assign rsp_name_char    = head.name_char;
   assign rsp_record_valid = head.record_valid;
   assign rsp_node_class   = head.node_class;
   assign rsp_loc_present  = head.loc_present;
   assign rsp_latitude     = head.latitude;
   assign rsp_longitude    = head.longitude;
   assign rsp_name_present = head.name_present;
   assign rsp_name_length  = head.name_length;
   assign rsp_last_result  = head.last_result;

   // Conditions watched by the checks below.
   assign empty_fire  = req_fire && req_empty_record;
   assign trunc_head  = rsp_valid && rsp_kind && !rsp_record_valid;
   assign trunc_clean = !rsp_loc_present && (rsp_latitude == 32'sd0) &&
                        (rsp_name_length == 5'd0);
   assign char_head   = rsp_valid && !rsp_kind;
   assign char_print  = (rsp_name_char >= 7'h20) && (rsp_name_char != 7'h7F);

   // An accepted empty record always leaves a result waiting on the next cycle.
   `ADP_ASSERT(a_empty_rsp, clock, reset, empty_fire |=> rsp_valid, "empty record gave no result")
   // Backpressure on req only while results are waiting.
   `ADP_ASSERT(a_stall_rsp, clock, reset, !req_ready |-> rsp_valid, "stall with empty queue")
   // A truncated record reports no location and no name.
   `ADP_ASSERT(a_trunc_zero, clock, reset, trunc_head |-> trunc_clean, "truncated summary has data")
   // Name characters are printable only.
   `ADP_ASSERT(a_char_print, clock, reset, char_head |-> char_print, "unprintable name char")

endmodule

// ===== rtl/adp_parser.sv =====
// Record parser state and per-byte result generation.
module adp_parser #(
   parameter int NAME_CAPACITY = adp_pkg::NAME_CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   input  logic                   empty_record,
   output adp_pkg::parse_out_type parse_out
);

   localparam int CW = $clog2(NAME_CAPACITY);
   localparam logic [CW-1:0] NAME_CLOSE_AT = CW'(NAME_CAPACITY - 1);

   localparam logic [2:0] ST_FLAGS = 3'd0;
   localparam logic [2:0] ST_LOC   = 3'd1;
   localparam logic [2:0] ST_F1    = 3'd2;
   localparam logic [2:0] ST_F2    = 3'd3;
   localparam logic [2:0] ST_NAME  = 3'd4;
   localparam logic [2:0] ST_SKIP  = 3'd5;

   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   logic [2:0]        stage_ff,       stage_in;
   logic [2:0]        fbc_ff,         fbc_in;
   logic [3:0]        flags_ff,       flags_in;
   logic [3:0]        type_ff,        type_in;
   logic [31:0]       lat_ff,         lat_in;
   logic [31:0]       lon_ff,         lon_in;
   logic              loc_seen_ff,    loc_seen_in;
   logic [CW-1:0]     chars_ff,       chars_in;
   logic              closed_ff,      closed_in;

   logic              char_hit;
   logic              rec_valid;
   logic [31:0]       byte_wide;
   adp_pkg::result_type char_res;
   adp_pkg::result_type sum_res;

   // Pick the next announced section after stage s.
   function automatic logic [2:0] next_stage(input logic [2:0] s, input logic [3:0] f);
      logic [2:0] r;
      if (s < ST_LOC && f[0]) begin
         r = ST_LOC;
      end else if (s < ST_F1 && f[1]) begin
         r = ST_F1;
      end else if (s < ST_F2 && f[2]) begin
         r = ST_F2;
      end else if (f[3]) begin
         r = ST_NAME;
      end else begin
         r = ST_SKIP;
      end
      return r;
   endfunction

   function automatic adp_pkg::result_type summary(
      input logic          valid,
      input logic [3:0]    ntype,
      input logic          loc,
      input logic [31:0]   lat,
      input logic [31:0]   lon,
      input logic [CW-1:0] chars
   );
      adp_pkg::result_type r;
      logic [6:0]          cw;
      r = '0;
      cw = 7'(chars);
      r.kind = adp_pkg::KIND_SUMMARY;
      r.record_valid = valid;
      r.node_class = ntype;
      if (valid) begin
         r.loc_present = loc;
         r.latitude = lat;
         r.longitude = lon;
         r.name_present = (cw != 7'd0);
         r.name_length = (cw > 7'd31) ? 5'd31 : cw[4:0];
      end
      return r;
   endfunction

   assign byte_wide = {24'd0, data_byte};

   always_comb begin
      stage_in    = stage_ff;
      fbc_in      = fbc_ff;
      flags_in    = flags_ff;
      type_in     = type_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      loc_seen_in = loc_seen_ff;
      chars_in    = chars_ff;
      closed_in   = closed_ff;
      char_hit    = 1'b0;
      char_res    = '0;
      rec_valid   = 1'b1;
      sum_res     = '0;
      parse_out   = '0;

      if (empty_record) begin
         stage_in    = ST_FLAGS;
         fbc_in      = '0;
         flags_in    = '0;
         type_in     = '0;
         lat_in      = '0;
         lon_in      = '0;
         loc_seen_in = 1'b0;
         chars_in    = '0;
         closed_in   = 1'b0;
         sum_res     = summary(1'b1, 4'd0, 1'b0, 32'd0, 32'd0, '0);
         sum_res.last_result = 1'b1;
         parse_out.count = 2'd1;
         parse_out.first = sum_res;
      end else begin
         unique case (stage_ff)
            ST_FLAGS: begin
               type_in  = data_byte[3:0];
               flags_in = data_byte[7:4];
               fbc_in   = '0;
               stage_in = next_stage(ST_FLAGS, data_byte[7:4]);
            end
            ST_LOC: begin
               if (!fbc_ff[2]) begin
                  lat_in = lat_ff | (byte_wide << {fbc_ff[1:0], 3'b000});
               end else begin
                  lon_in = lon_ff | (byte_wide << {fbc_ff[1:0], 3'b000});
               end
               fbc_in = fbc_ff + 3'd1;
               if (fbc_ff == 3'd7) begin
                  loc_seen_in = 1'b1;
                  fbc_in      = '0;
                  stage_in    = next_stage(ST_LOC, flags_ff);
               end
            end
            ST_F1, ST_F2: begin
               fbc_in = fbc_ff + 3'd1;
               if (fbc_ff >= 3'd1) begin
                  fbc_in   = '0;
                  stage_in = next_stage(stage_ff, flags_ff);
               end
            end
            ST_NAME: begin
               if (!closed_ff) begin
                  if (data_byte == 8'd0) begin
                     closed_in = 1'b1;
                  end else if (data_byte >= PRINT_LO && data_byte <= PRINT_HI) begin
                     char_hit           = 1'b1;
                     char_res.kind      = adp_pkg::KIND_CHAR;
                     char_res.name_char = data_byte[6:0];
                     chars_in           = chars_ff + CW'(1);
                     if (chars_in >= NAME_CLOSE_AT) begin
                        closed_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase

         if (last_byte) begin
            rec_valid = !(stage_in == ST_LOC || stage_in == ST_F1 || stage_in == ST_F2);
            sum_res = summary(rec_valid, type_in, loc_seen_in, lat_in, lon_in, chars_in);
            sum_res.last_result = 1'b1;
            stage_in    = ST_FLAGS;
            fbc_in      = '0;
            flags_in    = '0;
            type_in     = '0;
            lat_in      = '0;
            lon_in      = '0;
            loc_seen_in = 1'b0;
            chars_in    = '0;
            closed_in   = 1'b0;
         end

         if (char_hit && last_byte) begin
            parse_out.count  = 2'd2;
            parse_out.first  = char_res;
            parse_out.second = sum_res;
         end else if (char_hit) begin
            char_res.last_result = 1'b1;
            parse_out.count = 2'd1;
            parse_out.first = char_res;
         end else if (last_byte) begin
            parse_out.count = 2'd1;
            parse_out.first = sum_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= ST_FLAGS;
         fbc_ff      <= '0;
         flags_ff    <= '0;
         type_ff     <= '0;
         lat_ff      <= '0;
         lon_ff      <= '0;
         loc_seen_ff <= 1'b0;
         chars_ff    <= '0;
         closed_ff   <= 1'b0;
      end else if (accept) begin
         stage_ff    <= stage_in;
         fbc_ff      <= fbc_in;
         flags_ff    <= flags_in;
         type_ff     <= type_in;
         lat_ff      <= lat_in;
         lon_ff      <= lon_in;
         loc_seen_ff <= loc_seen_in;
         chars_ff    <= chars_in;
         closed_ff   <= closed_in;
      end
   end

endmodule

// ===== rtl/adp_rsp_fifo.sv =====
// Result queue: takes up to two results a cycle, delivers one while pop is high.
module adp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  adp_pkg::parse_out_type parse_out,
   input  logic                   pop,
   output logic                   room,
   output logic                   out_valid,
   output adp_pkg::result_type    out_data
);

   adp_pkg::result_type mem_ff [adp_pkg::RSP_DEPTH];

   logic [adp_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [adp_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [adp_pkg::RSP_CNT_W-1:0] count_ff,  count_in;
   logic [1:0]                    wr_cnt;
   logic                          do_pop;

   assign wr_cnt    = push ? parse_out.count : 2'd0;
   assign do_pop    = pop && (count_ff != '0);
   assign room      = (count_ff <= adp_pkg::RSP_CNT_W'(adp_pkg::RSP_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + adp_pkg::RSP_PTR_W'(wr_cnt);
      rd_ptr_in = rd_ptr_ff + adp_pkg::RSP_PTR_W'(do_pop);
      count_in  = count_ff + adp_pkg::RSP_CNT_W'(wr_cnt) - adp_pkg::RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= parse_out.first;
      end
      if (wr_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + adp_pkg::RSP_PTR_W'(1)] <= parse_out.second;
      end
   end

endmodule

// ===== sim/advert_app_data_parser_unit_checker.sv =====
// Checker that predicts and compares the results of the advertisement data parser.
`timescale 1ns / 1ps

module advert_app_data_parser_unit_checker #(
   parameter int NAME_CAPACITY = adp_pkg::NAME_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               req_empty_record,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_kind,
   input  logic [6:0]         rsp_name_char,
   input  logic               rsp_record_valid,
   input  logic [3:0]         rsp_node_class,
   input  logic               rsp_loc_present,
   input  logic signed [31:0] rsp_latitude,
   input  logic signed [31:0] rsp_longitude,
   input  logic               rsp_name_present,
   input  logic [4:0]         rsp_name_length,
   input  logic               rsp_last_result,
   output int                 fail_count,
   output int                 results_owed
);

   typedef enum logic [2:0] {
      STAGE_FLAGS,
      STAGE_LOC,
      STAGE_F1,
      STAGE_F2,
      STAGE_NAME,
      STAGE_SKIP
   } parse_stage_type;

   // Announcement bits, as seen in the upper nibble of the flags byte.
   localparam logic [3:0] ANN_LOCATION = 4'h1;
   localparam logic [3:0] ANN_FEATURE1 = 4'h2;
   localparam logic [3:0] ANN_FEATURE2 = 4'h4;
   localparam logic [3:0] ANN_NAME     = 4'h8;
   localparam logic [7:0] CHAR_FIRST   = 8'h20;
   localparam logic [7:0] CHAR_LAST    = 8'h7E;
   localparam logic [7:0] NAME_END     = 8'h00;

   parse_stage_type stage;
   int              byte_index;
   logic [3:0]      ann_bits;
   logic [3:0]      node_nibble;
   logic [31:0]     lat_word;
   logic [31:0]     lon_word;
   logic            loc_done;
   int              char_count;
   logic            name_done;

   adp_pkg::result_type predicted_results[$];

   initial fail_count = 0;
   initial results_owed = 0;

   task automatic clear_record();
      stage       = STAGE_FLAGS;
      byte_index  = 0;
      ann_bits    = '0;
      node_nibble = '0;
      lat_word    = '0;
      lon_word    = '0;
      loc_done    = 1'b0;
      char_count  = 0;
      name_done   = 1'b0;
   endtask

   function automatic parse_stage_type stage_after(input parse_stage_type s);
      if (s < STAGE_LOC && (ann_bits & ANN_LOCATION) != 0) return STAGE_LOC;
      if (s < STAGE_F1 && (ann_bits & ANN_FEATURE1) != 0) return STAGE_F1;
      if (s < STAGE_F2 && (ann_bits & ANN_FEATURE2) != 0) return STAGE_F2;
      if ((ann_bits & ANN_NAME) != 0) return STAGE_NAME;
      return STAGE_SKIP;
   endfunction

   function automatic adp_pkg::result_type record_summary(input logic ok);
      adp_pkg::result_type r;
      r              = '0;
      r.kind         = adp_pkg::KIND_SUMMARY;
      r.record_valid = ok;
      r.node_class   = node_nibble;
      if (ok) begin
         r.loc_present  = loc_done;
         r.latitude     = lat_word;
         r.longitude    = lon_word;
         r.name_present = (char_count > 0);
         r.name_length  = (char_count > 31) ? 5'd31 : char_count[4:0];
      end
      return r;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic last, input logic empty);
      adp_pkg::result_type produced[2];
      adp_pkg::result_type r;
      int                  n;
      logic                ok;
      n = 0;
      if (empty) begin
         // drop any partial record
         clear_record();
         produced[n] = record_summary(1'b1);
         n++;
      end else begin
         case (stage)
            STAGE_FLAGS: begin
               node_nibble = b[3:0];
               ann_bits    = b[7:4];
               byte_index  = 0;
               stage       = stage_after(STAGE_FLAGS);
            end
            STAGE_LOC: begin
               if (byte_index < 4) lat_word |= 32'(b) << (8 * byte_index);
               else lon_word |= 32'(b) << (8 * (byte_index - 4));
               byte_index++;
               if (byte_index >= 8) begin
                  loc_done   = 1'b1;
                  byte_index = 0;
                  stage      = stage_after(STAGE_LOC);
               end
            end
            STAGE_F1, STAGE_F2: begin
               byte_index++;
               if (byte_index >= 2) begin
                  byte_index = 0;
                  stage      = stage_after(stage);
               end
            end
            STAGE_NAME: begin
               if (!name_done) begin
                  if (b == NAME_END) begin
                     name_done = 1'b1;
                  end else if (b >= CHAR_FIRST && b <= CHAR_LAST) begin
                     r           = '0;
                     r.kind      = adp_pkg::KIND_CHAR;
                     r.name_char = b[6:0];
                     produced[n] = r;
                     n++;
                     char_count++;
                     if (char_count + 1 >= NAME_CAPACITY) name_done = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (last) begin
            // owed location or feature bytes make the record invalid
            ok = !(stage == STAGE_LOC || stage == STAGE_F1 || stage == STAGE_F2);
            produced[n] = record_summary(ok);
            n++;
            clear_record();
         end
      end
      if (n > 0) begin
         r = produced[n-1];
         r.last_result = 1'b1;
         produced[n-1] = r;
      end
      for (int i = 0; i < n; i++) predicted_results.push_back(produced[i]);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      adp_pkg::result_type want;
      if (reset) begin
         clear_record();
         predicted_results.delete();
      end else begin
         if (req_valid && req_ready)
            parse_byte(req_data_byte, req_last_byte, req_empty_record);
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("result transaction with no prediction waiting");
               fail_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("name_char", 32'(want.name_char), 32'(rsp_name_char));
               check_field("record_valid", 32'(want.record_valid), 32'(rsp_record_valid));
               check_field("node_class", 32'(want.node_class), 32'(rsp_node_class));
               check_field("loc_present", 32'(want.loc_present), 32'(rsp_loc_present));
               check_field("latitude", want.latitude, rsp_latitude);
               check_field("longitude", want.longitude, rsp_longitude);
               check_field("name_present", 32'(want.name_present), 32'(rsp_name_present));
               check_field("name_length", 32'(want.name_length), 32'(rsp_name_length));
               check_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
            end
         end
      end
      results_owed <= predicted_results.size();
   end

endmodule

// ===== sim/advert_app_data_parser_unit_test.sv =====
// Top of the advertisement data parser testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module advert_app_data_parser_unit_test;

   localparam int NAME_CAPACITY  = adp_pkg::NAME_CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 750;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RESET_CYCLES   = 10;

   // Flags byte bits: upper nibble announces fields, low nibble is the node class.
   localparam logic [7:0] FLAG_LOCATION = 8'h10;
   localparam logic [7:0] FLAG_FEATURE1 = 8'h20;
   localparam logic [7:0] FLAG_FEATURE2 = 8'h40;
   localparam logic [7:0] FLAG_NAME     = 8'h80;
   localparam logic [7:0] CHAR_FIRST    = 8'h20;
   localparam logic [7:0] CHAR_LAST     = 8'h7E;

   // Every input starts at a known value; reset is held from time zero.
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic [7:0]         req_data_byte    = '0;
   logic               req_last_byte    = 1'b0;
   logic               req_empty_record = 1'b0;
   logic               rsp_ready        = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_kind;
   logic [6:0]         rsp_name_char;
   logic               rsp_record_valid;
   logic [3:0]         rsp_node_class;
   logic               rsp_loc_present;
   logic signed [31:0] rsp_latitude;
   logic signed [31:0] rsp_longitude;
   logic               rsp_name_present;
   logic [4:0]         rsp_name_length;
   logic               rsp_last_result;

   int fail_count;
   int results_owed;
   int cycle_count;
   int items_sent   = 0;
   int send_idle    = 0;
   int recv_idle    = 0;

   advert_app_data_parser_unit #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_empty_record(req_empty_record),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_name_char   (rsp_name_char),
      .rsp_record_valid(rsp_record_valid),
      .rsp_node_class  (rsp_node_class),
      .rsp_loc_present (rsp_loc_present),
      .rsp_latitude    (rsp_latitude),
      .rsp_longitude   (rsp_longitude),
      .rsp_name_present(rsp_name_present),
      .rsp_name_length (rsp_name_length),
      .rsp_last_result (rsp_last_result)
   );

   advert_app_data_parser_unit_checker #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_empty_record(req_empty_record),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_name_char   (rsp_name_char),
      .rsp_record_valid(rsp_record_valid),
      .rsp_node_class  (rsp_node_class),
      .rsp_loc_present (rsp_loc_present),
      .rsp_latitude    (rsp_latitude),
      .rsp_longitude   (rsp_longitude),
      .rsp_name_present(rsp_name_present),
      .rsp_name_length (rsp_name_length),
      .rsp_last_result (rsp_last_result),
      .fail_count      (fail_count),
      .results_owed    (results_owed)
   );

   // 10 ns clock: low half, then high half.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: drop ready at random, at the rate the current phase sets.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Watchdog: end the run as failed if it overruns the cycle budget.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Offer one transaction and hold it until it is accepted. Idle first, at random;
   // valid is only lowered in a cycle where it is not raised again.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_last_byte    <= last;
      req_empty_record <= empty;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Pick one name byte: mostly printable, with the odd terminator or raw byte.
   function automatic logic [7:0] name_byte();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
   endfunction

   // Build one record and send it: mostly well formed with random content, the rest
   // truncated records, empty records and loose noise bytes.
   task automatic send_record();
      logic [7:0] body[$];
      logic [7:0] flags;
      int         pick;
      int         count;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 12) begin
         // noise: loose bytes that may leave the parser mid-record
         count = $urandom_range(1, 4);
         repeat (count) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      end else begin
         flags = 8'($urandom_range(0, 255));
         body.push_back(flags);
         if ((flags & FLAG_LOCATION) != 0)
            repeat (8) body.push_back(8'($urandom_range(0, 255)));
         if ((flags & FLAG_FEATURE1) != 0)
            repeat (2) body.push_back(8'($urandom_range(0, 255)));
         if ((flags & FLAG_FEATURE2) != 0)
            repeat (2) body.push_back(8'($urandom_range(0, 255)));
         if ((flags & FLAG_NAME) != 0) begin
            // a few names run past capacity
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(NAME_CAPACITY - 4,
                                                                 NAME_CAPACITY + 8)
                                                : $urandom_range(0, 10);
            repeat (count) body.push_back(name_byte());
         end else begin
            count = $urandom_range(0, 3);
            repeat (count) body.push_back(8'($urandom_range(0, 255)));
         end
         // truncate some records at a random point
         if (pick < 24) begin
            count = $urandom_range(1, body.size());
            while (body.size() > count) void'(body.pop_back());
         end
         foreach (body[i]) send_byte(body[i], (i == body.size() - 1), 1'b0);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty record, flags-only record, truncated location.
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h0F, 1'b1, 1'b0);
      send_byte(FLAG_LOCATION, 1'b1, 1'b0);
      // Full record: extreme location words, both features, name edge characters,
      // a terminator and a byte after it that must be ignored.
      send_byte(8'hF3, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b0, 1'b0);
      send_byte(CHAR_FIRST, 1'b0, 1'b0);
      send_byte(CHAR_LAST, 1'b0, 1'b0);
      send_byte(8'h1F, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h41, 1'b1, 1'b0);
      // Partial record discarded by an empty record, then a truncated feature.
      send_byte(FLAG_FEATURE1 | 8'h05, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(FLAG_FEATURE2 | 8'h0A, 1'b0, 1'b0);
      send_byte(8'h99, 1'b1, 1'b0);

      // Hold off until every predicted result has been delivered.
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);

      // Random records in three phases of idling.
      begin
         int random_start;
         random_start = items_sent;
         send_idle = 16;
         recv_idle = 52;
         while (items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - random_start >= 2 * RANDOM_ITEMS / 3) begin
               send_idle = 0;
               recv_idle = 0;
            end else if (items_sent - random_start >= RANDOM_ITEMS / 3) begin
               send_idle = 52;
               recv_idle = 16;
            end
            send_record();
         end
      end

      // Drain: wait for the last results, then let the clock run on before the verdict.
      req_valid <= 1'b0;
      recv_idle = 0;
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
